[src/imh_pkg.sv]
// Shared types, constants and the opcode key fold for the instruction mix histogram.
// Used by every module of the block; depends on nothing.
package imh_pkg;

  localparam int KEY_BITS = 17;
  localparam int ADDR_BITS = KEY_BITS + 1;
  localparam int COUNTER_BITS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [31:0] BASE_RESET = 32'hFFFF_8000;

  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [5:0] OP_VEC = 6'd4;
  localparam logic [5:0] OP_XL = 6'd19;
  localparam logic [5:0] OP_X = 6'd31;
  localparam logic [5:0] OP_FPS = 6'd59;
  localparam logic [5:0] OP_FPD = 6'd63;
  localparam logic [5:0] OP_MTSPR_KEY = 6'd0;
  localparam logic [5:0] OP_MFSPR_KEY = 6'd1;
  localparam logic [9:0] XO_MTSPR = 10'd467;
  localparam logic [9:0] XO_MFSPR = 10'd339;
  localparam logic [4:0] XO_FP_A_MIN = 5'd18;

  localparam int CMP_COUNT = 13;
  localparam logic [9:0] CMP_CODES [CMP_COUNT] = '{
    10'd6, 10'd70, 10'd134, 10'd198, 10'd454, 10'd518, 10'd582,
    10'd646, 10'd710, 10'd774, 10'd838, 10'd902, 10'd966
  };

  typedef struct packed {
    logic                is_read;
    logic                bank;
    logic [KEY_BITS-1:0] key;
  } imh_cmd_t;

  function automatic logic [KEY_BITS-1:0] fold_key(input logic [31:0] w);
    logic [5:0]  op;
    logic [5:0]  prim;
    logic [10:0] sub;
    logic [9:0]  x10;
    logic [4:0]  x5;
    logic        is_cmp;
    op = w[31:26];
    prim = op;
    sub = '0;
    x10 = w[10:1];
    x5 = w[5:1];
    is_cmp = 1'b0;
    for (int i = 0; i < CMP_COUNT; i++) begin
      if (w[9:0] == CMP_CODES[i]) is_cmp = 1'b1;
    end
    unique case (op)
      OP_VEC: begin
        priority if (w[5:4] == 2'b10) sub = {1'b1, 4'b0000, w[5:0]};
        else if (is_cmp) sub = {1'b0, w[9:0]};
        else sub = w[10:0];
      end
      OP_XL: sub = {1'b0, x10};
      OP_X: begin
        priority if (x10 == XO_MTSPR) begin
          prim = OP_MTSPR_KEY;
          sub = {1'b0, w[15:11], w[20:16]};
        end else if (x10 == XO_MFSPR) begin
          prim = OP_MFSPR_KEY;
          sub = {1'b0, w[15:11], w[20:16]};
        end else begin
          sub = {1'b0, x10};
        end
      end
      OP_FPS: sub = {6'b000000, x5};
      OP_FPD: begin
        if (x5 >= XO_FP_A_MIN) sub = {1'b1, 5'b00000, x5};
        else sub = {1'b0, x10};
      end
      default: sub = '0;
    endcase
    return {prim, sub};
  endfunction

endpackage

[src/imh_ifs.sv]
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on imh_pkg for the key width and the default counter width.
interface imh_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [31:0]                  instr_word;
  logic [31:0]                  instr_pc;
  logic                         read_bank;
  logic [imh_pkg::KEY_BITS-1:0] read_key;
  modport source (output valid, req_type, instr_word, instr_pc, read_bank, read_key,
                  input ready);
  modport sink (input valid, req_type, instr_word, instr_pc, read_bank, read_key,
                output ready);
endinterface

interface imh_res_if #(parameter int CNT_W = imh_pkg::COUNTER_BITS_DEF);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] read_count;
  modport source (output valid, read_count, input ready);
  modport sink (input valid, read_count, output ready);
endinterface

interface imh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] commpage_base;
  modport source (output valid, commpage_base, input ready);
  modport sink (input valid, commpage_base, output ready);
endinterface

[src/imh_front.sv]
// Front end: holds the commpage base, accepts requests, folds the opcode key
// and picks the bank. Depends on imh_pkg and imh_ifs.
module imh_front (
  input  logic              clk,
  input  logic              rst,
  imh_req_if.sink           req,
  imh_cfg_if.sink           cfg,
  input  logic              q_full,
  input  logic              clearing,
  output logic              push,
  output imh_pkg::imh_cmd_t push_data
);
  import imh_pkg::*;

  logic [31:0] commpage_base;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      commpage_base <= BASE_RESET;
    end else if (cfg.valid) begin
      commpage_base <= cfg.commpage_base;
    end
  end

  assign req.ready = !q_full && !clearing;
  assign push = req.valid && req.ready;

  always_comb begin
    push_data.is_read = (req.req_type == REQ_READ);
    if (req.req_type == REQ_READ) begin
      push_data.bank = req.read_bank;
      push_data.key = req.read_key;
    end else begin
      push_data.bank = (req.instr_pc >= commpage_base);
      push_data.key = fold_key(req.instr_word);
    end
  end

endmodule

[src/imh_queue.sv]
// Short command queue between the front end and the counter engine.
// Depends on imh_pkg for the command type.
module imh_queue #(
  parameter int DEPTH = imh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  imh_pkg::imh_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output imh_pkg::imh_cmd_t pop_data
);
  import imh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  imh_cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        if (wr_ptr == PTR_W'(DEPTH - 1)) wr_ptr <= '0;
        else wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        if (rd_ptr == PTR_W'(DEPTH - 1)) rd_ptr <= '0;
        else rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[src/imh_back.sv]
// Counter engine: counter memory with clearing sweep, read-modify-write of one
// counter per command and the result register. Depends on imh_pkg and imh_ifs.
module imh_back #(
  parameter int COUNTER_BITS = imh_pkg::COUNTER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  imh_pkg::imh_cmd_t q_data,
  output logic              pop,
  output logic              clearing,
  imh_res_if.source         res
);
  import imh_pkg::*;

  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [COUNTER_BITS-1:0] mem [MEM_DEPTH];
  logic [COUNTER_BITS-1:0] rd_data;
  logic [COUNTER_BITS-1:0] out_data;
  logic [1:0]              state;
  logic [ADDR_BITS-1:0]    clr_addr;
  imh_cmd_t                cmd;
  logic                    out_valid;
  logic                    mem_we;
  logic [ADDR_BITS-1:0]    mem_waddr;
  logic [COUNTER_BITS-1:0] mem_wdata;
  logic                    load_out;

  assign clearing = (state == ST_CLEAR);
  assign pop = (state == ST_IDLE) && q_valid;
  assign load_out = (state == ST_EXEC) && cmd.is_read && (!out_valid || res.ready);
  assign res.valid = out_valid;
  assign res.read_count = out_data;

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = {cmd.bank, cmd.key};
    mem_wdata = rd_data + COUNTER_BITS'(1);
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if ((state == ST_EXEC) && !cmd.is_read) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (pop) rd_data <= mem[{q_data.bank, q_data.key}];
  end

  always_ff @(posedge clk) begin
    if (pop) cmd <= q_data;
    if (load_out) out_data <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (!cmd.is_read || load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/instruction_mix_histogram.sv]
// Top level of the instruction mix histogram: front end, command queue and
// counter engine. Depends on imh_pkg, imh_ifs, imh_front, imh_queue, imh_back.
//
// Channels: req takes count and read requests, res returns one counter per
// read request, cfg writes the commpage base (ready is always high).
// A count request folds the instruction word into a 17-bit opcode key, picks
// bank 1 when the pc is at or above the commpage base, and increments that
// counter, wrapping at COUNTER_BITS. A read request returns the counter for
// read_bank and read_key.
// The counter engine takes one request at a time: in IDLE it pops it and reads the
// counter memory, in EXEC it writes the counter back or loads the result register.
// A read reaches res.valid through the queue, IDLE and EXEC; the queue of
// QUEUE_DEPTH entries lets req keep moving while res stalls.
// Reset: a clearing sweep writes zero to all 262144 counters, one per cycle;
// req.ready stays low throughout the sweep. Config writes are taken anytime.
// A stalled result holds in the output register; further reads wait in the
// queue, and req.ready drops once the queue is full.
module instruction_mix_histogram #(
  parameter int COUNTER_BITS = imh_pkg::COUNTER_BITS_DEF,
  parameter int QUEUE_DEPTH = imh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  imh_req_if.sink   req,
  imh_res_if.source res,
  imh_cfg_if.sink   cfg
);
  import imh_pkg::*;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  logic     clearing;
  imh_cmd_t push_data;
  imh_cmd_t pop_data;

  imh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_data (push_data)
  );

  imh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  imh_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (pop_data),
    .pop      (pop),
    .clearing (clearing),
    .res      (res)
  );

  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("request taken during clearing sweep");

  a_no_res_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !res.valid && !q_valid)
    else $error("work pending during clearing sweep");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into full queue");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid && !clearing)
    else $error("pop from empty queue");

endmodule

[tb/sv/instruction_mix_histogram_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for instruction_mix_histogram: directed and random count and read
// traffic under random stalls, checked against an in-bench opcode-key histogram.
// Depends on imh_pkg, imh_ifs and the instruction_mix_histogram RTL.
module instruction_mix_histogram_tb;
  import imh_pkg::*;

  localparam int CNT_W = COUNTER_BITS_DEF;
  localparam logic [10:0] SUB_WIDE = 11'h400;
  localparam int POOL_SIZE = 16;
  localparam int SEEN_MAX = 64;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam longint TIMEOUT_NS = 64'd12_000_000;

  logic clk = 1'b0;
  logic rst;

  imh_req_if                   req_ch ();
  imh_res_if #(.CNT_W(CNT_W))  res_ch ();
  imh_cfg_if                   cfg_ch ();

  instruction_mix_histogram #(.COUNTER_BITS(CNT_W)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  logic [CNT_W-1:0]     mix_count [bit [ADDR_BITS-1:0]];
  logic [CNT_W-1:0]     pending_counts [$];
  bit   [ADDR_BITS-1:0] seen_slots [$];
  logic [31:0]          word_pool [POOL_SIZE];
  logic [31:0]          commpage_model;
  logic [CNT_W-1:0]     want;
  bit                   gaps_on = 1'b1;
  int                   hold_cycles = 0;
  int                   errors = 0;
  int                   n_count = 0;
  int                   n_read = 0;
  int                   n_cfg = 0;
  int                   fill_stalls = 0;

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [KEY_BITS-1:0] opcode_key(input logic [31:0] w);
    logic [5:0]  prim;
    logic [10:0] sub;
    logic [9:0]  xo;
    logic [4:0]  xa;
    logic        vcmp;
    prim = w[31:26];
    xo = w[10:1];
    xa = w[5:1];
    sub = '0;
    vcmp = 1'b0;
    for (int i = 0; i < CMP_COUNT; i++) begin
      if (w[9:0] == CMP_CODES[i]) vcmp = 1'b1;
    end
    case (prim)
      OP_VEC: begin
        if (w[5:4] == 2'b10) sub = SUB_WIDE | w[5:0];
        else if (vcmp) sub = {1'b0, w[9:0]};
        else sub = w[10:0];
      end
      OP_XL: sub = {1'b0, xo};
      OP_X: begin
        if (xo == XO_MTSPR || xo == XO_MFSPR) begin
          prim = (xo == XO_MTSPR) ? OP_MTSPR_KEY : OP_MFSPR_KEY;
          sub = {1'b0, w[15:11], w[20:16]};
        end else begin
          sub = {1'b0, xo};
        end
      end
      OP_FPS: sub = {6'b0, xa};
      OP_FPD: sub = (xa >= XO_FP_A_MIN) ? (SUB_WIDE | xa) : {1'b0, xo};
      default: sub = '0;
    endcase
    return {prim, sub};
  endfunction

  function automatic logic [31:0] gen_class_word(input int cls);
    logic [31:0] w;
    w = $urandom;
    case (cls)
      0: begin
        w[31:26] = OP_VEC;
        w[5:4] = 2'b10;
      end
      1: begin
        w[31:26] = OP_VEC;
        w[9:0] = CMP_CODES[$urandom_range(0, CMP_COUNT - 1)];
      end
      2: w[31:26] = OP_VEC;
      3: w[31:26] = OP_XL;
      4: w[31:26] = OP_X;
      5: begin
        w[31:26] = OP_X;
        w[10:1] = XO_MTSPR;
      end
      6: begin
        w[31:26] = OP_X;
        w[10:1] = XO_MFSPR;
      end
      7: w[31:26] = OP_FPS;
      8: w[31:26] = OP_FPD;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 9) < 3) return word_pool[$urandom_range(0, POOL_SIZE - 1)];
    return gen_class_word($urandom_range(0, 10));
  endfunction

  function automatic logic [31:0] pick_pc();
    case ($urandom_range(0, 7))
      0: return commpage_model;
      1: return commpage_model - 32'd1;
      2: return commpage_model + 32'($urandom_range(1, 16));
      3: return 32'h0000_0000;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input logic typ, input logic [31:0] word, input logic [31:0] pc,
                          input logic bank, input logic [KEY_BITS-1:0] key);
    int gap;
    bit [ADDR_BITS-1:0] slot;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= typ;
    req_ch.instr_word <= word;
    req_ch.instr_pc <= pc;
    req_ch.read_bank <= bank;
    req_ch.read_key <= key;
    @(posedge clk);
    while (!req_ch.ready) begin
      if (hold_cycles > 0) fill_stalls++;
      @(posedge clk);
    end
    if (typ == REQ_COUNT) begin
      slot = {pc >= commpage_model, opcode_key(word)};
      mix_count[slot] = (mix_count.exists(slot) ? mix_count[slot] : '0) + 1'b1;
      seen_slots.push_back(slot);
      if (seen_slots.size() > SEEN_MAX) void'(seen_slots.pop_front());
      n_count++;
    end else begin
      slot = {bank, key};
      pending_counts.push_back(mix_count.exists(slot) ? mix_count[slot] : '0);
      n_read++;
    end
  endtask

  task automatic write_base(input logic [31:0] base);
    cfg_ch.valid <= 1'b1;
    cfg_ch.commpage_base <= base;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    commpage_model = base;
    n_cfg++;
  endtask

  // Drop the request, wait out outstanding reads, then let trailing counts retire.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    bit [ADDR_BITS-1:0] slot;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      send_req(REQ_COUNT, pick_word(), pick_pc(), 1'($urandom), 17'($urandom));
    end else begin
      if (pick < 82 && seen_slots.size() != 0)
        slot = seen_slots[$urandom_range(0, seen_slots.size() - 1)];
      else if (pick < 91)
        slot = {1'($urandom), opcode_key(word_pool[$urandom_range(0, POOL_SIZE - 1)])};
      else
        slot = 18'($urandom);
      send_req(REQ_READ, $urandom, $urandom, slot[ADDR_BITS-1], slot[KEY_BITS-1:0]);
    end
  endtask

  task automatic test_directed_keys();
    logic [31:0] words [11];
    logic [31:0] pcs [11];
    words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1000_0022, 32'h1000_07C6, 32'h1000_07FF,
              32'h4C00_0020, 32'h7C00_0214, 32'h7C60_43A6, 32'h7C08_02A6, 32'hEC00_002B,
              32'hFC00_0090};
    for (int i = 0; i < 11; i++) begin
      if (i == 0) pcs[i] = 32'h0000_0000;
      else if (i == 1) pcs[i] = 32'hFFFF_FFFF;
      else if (i % 2 == 1) pcs[i] = commpage_model;
      else pcs[i] = commpage_model - 32'd1;
      send_req(REQ_COUNT, words[i], pcs[i], 1'b0, '0);
    end
    for (int i = 0; i < 11; i++)
      send_req(REQ_READ, ~words[i], ~pcs[i], pcs[i] >= commpage_model, opcode_key(words[i]));
    send_req(REQ_READ, '0, '0, 1'b1, '1);
    settle();
  endtask

  task automatic test_bank_boundary();
    logic [31:0] bases [4];
    bases[0] = 32'h0000_0000;
    bases[1] = 32'hFFFF_FFFF;
    bases[2] = $urandom;
    bases[3] = BASE_RESET;
    for (int b = 0; b < 4; b++) begin
      write_base(bases[b]);
      repeat (150) random_item();
      settle();
    end
  endtask

  task automatic test_result_backpressure();
    bit [ADDR_BITS-1:0] slot;
    gaps_on = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    for (int i = 0; i < 48; i++) begin
      if (i % 6 == 5) begin
        send_req(REQ_COUNT, pick_word(), pick_pc(), 1'b0, '0);
      end else begin
        slot = seen_slots[$urandom_range(0, seen_slots.size() - 1)];
        send_req(REQ_READ, $urandom, $urandom, slot[ADDR_BITS-1], slot[KEY_BITS-1:0]);
      end
    end
    gaps_on = 1'b1;
    settle();
  endtask

  task automatic test_random_mix(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      random_item();
    end
    gaps_on = 1'b1;
    settle();
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_counts.size() == 0) begin
        $error("read_count: no read pending, expected none, actual %0h", res_ch.read_count);
        errors++;
      end else begin
        want = pending_counts.pop_front();
        if (res_ch.read_count !== want) begin
          $error("read_count: expected %0h, actual %0h", want, res_ch.read_count);
          errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("instruction_mix_histogram regression: fail");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_COUNT;
    req_ch.instr_word <= '0;
    req_ch.instr_pc <= '0;
    req_ch.read_bank <= 1'b0;
    req_ch.read_key <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.commpage_base <= '0;
    commpage_model = BASE_RESET;
    for (int i = 0; i < POOL_SIZE; i++) word_pool[i] = gen_class_word($urandom_range(0, 10));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_keys();
    test_bank_boundary();
    test_result_backpressure();
    test_random_mix(430);

    $display("covered %0d count and %0d read transfers over %0d commpage base settings",
             n_count, n_read, n_cfg);
    $display("request side held by a full queue for %0d cycles during the result hold-off",
             fill_stalls);
    if (errors == 0) begin
      $display("instruction_mix_histogram regression: pass");
    end else begin
      $display("instruction_mix_histogram regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/imh_pkg.sv
src/imh_ifs.sv
src/imh_front.sv
src/imh_queue.sv
src/imh_back.sv
src/instruction_mix_histogram.sv
tb/sv/instruction_mix_histogram_tb.sv
